>>> hdl/pces_pkg.sv
package pces_pkg;

  localparam int DATA_W            = 32;
  localparam int COUNTER_WIDTH_DEF = 32;
  localparam int NUM_CH            = 4;
  localparam logic [1:0] SKIP_COUNT = 2'd2;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_STOP  = 2'd1,
    REQ_EVENT = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_OVERFLOW    = 2'd1,
    ST_BUSY        = 2'd2,
    ST_BAD_CHANNEL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE        = 2'd0,
    PH_WAIT_UPDATE = 2'd1,
    PH_WAIT_START  = 2'd2,
    PH_WAIT_END    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CFG_FOUR_CHANNEL = 2'd0,
    CFG_CONTINUOUS   = 2'd1,
    CFG_PERIOD_EN    = 2'd2,
    CFG_PULSE_EN     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic four_channel_mode;
    logic continuous_mode;
    logic report_period_enable;
    logic report_pulse_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                    req_type;
    logic [2:0]                    channel_sel;
    logic                          overflow_flag;
    logic [NUM_CH-1:0]             capture_flags;
    logic [NUM_CH-1:0][DATA_W-1:0] capture_value;
  } item_t;

  typedef struct packed {
    logic              report_valid;
    logic [2:0]        report_channel;
    logic [DATA_W-1:0] period_value;
    logic [DATA_W-1:0] pulse_value;
    logic [1:0]        status_code;
    logic              capture_armed;
    logic              update_request;
  } result_t;

  // complementary channel: 1<->2, 3<->4
  function automatic logic [2:0] partner_of(input logic [2:0] ch);
    logic [2:0] p;
    case (ch)
      3'd1:    p = 3'd2;
      3'd2:    p = 3'd1;
      3'd3:    p = 3'd4;
      3'd4:    p = 3'd3;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

  function automatic logic ch_in_range(input logic [2:0] ch);
    return (ch >= 3'd1) && (ch <= 3'(NUM_CH));
  endfunction

  function automatic logic flag_of(input logic [2:0] ch, input logic [NUM_CH-1:0] flags);
    logic [1:0] idx;
    idx = 2'(ch - 3'd1);
    return ch_in_range(ch) && flags[idx];
  endfunction

endpackage

>>> hdl/pces_core.sv
module pces_core #(
  parameter int COUNTER_WIDTH = pces_pkg::COUNTER_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  pces_pkg::cfg_t   cfg,
  input  pces_pkg::item_t  item,
  output pces_pkg::result_t res
);
  import pces_pkg::*;

  logic                     armed, armed_next;
  logic [2:0]               active_channel, active_channel_next;
  phase_t                   phase, phase_next;
  logic [1:0]               skip_left, skip_left_next;
  logic                     overflow_seen, overflow_seen_next;
  logic [COUNTER_WIDTH-1:0] period_hold, period_hold_next;
  logic [COUNTER_WIDTH-1:0] pulse_hold, pulse_hold_next;

  logic [2:0]               ch_part;
  logic [1:0]               idx_act, idx_part;
  logic                     flag_act, flag_part;
  logic [COUNTER_WIDTH-1:0] val_act, val_part;

  assign ch_part   = partner_of(active_channel);
  assign idx_act   = 2'(active_channel - 3'd1);
  assign idx_part  = 2'(ch_part - 3'd1);
  assign flag_act  = flag_of(active_channel, item.capture_flags);
  assign flag_part = flag_of(ch_part, item.capture_flags);
  assign val_act   = ch_in_range(active_channel) ?
                     item.capture_value[idx_act][COUNTER_WIDTH-1:0] : '0;
  assign val_part  = ch_in_range(ch_part) ?
                     item.capture_value[idx_part][COUNTER_WIDTH-1:0] : '0;

  always_comb begin
    logic ch_ok;
    logic report;
    armed_next          = armed;
    active_channel_next = active_channel;
    phase_next          = phase;
    skip_left_next      = skip_left;
    overflow_seen_next  = overflow_seen;
    period_hold_next    = period_hold;
    pulse_hold_next     = pulse_hold;
    report              = 1'b0;
    res                 = '0;
    res.report_channel  = active_channel;
    ch_ok = cfg.four_channel_mode ? ch_in_range(item.channel_sel) :
            (item.channel_sel == 3'd1 || item.channel_sel == 3'd2);

    case (item.req_type) inside
      REQ_START, REQ_STOP: begin
        res.report_channel = item.channel_sel;
        if (!ch_ok) begin
          res.status_code = ST_BAD_CHANNEL;
        end else if (item.req_type == REQ_STOP) begin
          armed_next = 1'b0;
          phase_next = PH_IDLE;
        end else if (armed) begin
          res.status_code = ST_BUSY;
        end else begin
          armed_next          = 1'b1;
          active_channel_next = item.channel_sel;
          phase_next          = PH_WAIT_START;
          skip_left_next      = cfg.four_channel_mode ? 2'd0 : SKIP_COUNT;
          overflow_seen_next  = 1'b0;
          res.update_request  = 1'b1;
        end
      end
      REQ_EVENT: begin
        if (armed) begin
          if (skip_left != 2'd0) begin
            if (item.capture_flags != '0) skip_left_next = skip_left - 2'd1;
          end else begin
            report = 1'b1;
            if (item.overflow_flag) begin
              if (cfg.four_channel_mode && phase == PH_WAIT_UPDATE) phase_next = PH_WAIT_END;
              else overflow_seen_next = 1'b1;
            end
            if (!cfg.four_channel_mode) begin
              if (flag_act || flag_part) begin
                period_hold_next = val_act;
                pulse_hold_next  = val_part;
              end
            end else begin
              if (phase_next == PH_WAIT_START && flag_act) begin
                phase_next         = PH_WAIT_UPDATE;
                res.update_request = 1'b1;
              end else if ((phase_next == PH_WAIT_UPDATE || phase_next == PH_WAIT_END)
                           && flag_act) begin
                phase_next       = PH_IDLE;
                period_hold_next = val_act;
                pulse_hold_next  = val_part;
              end
              if (phase_next != PH_IDLE) report = 1'b0;
            end
          end
          if (report) begin
            res.report_valid = 1'b1;
            res.status_code  = overflow_seen_next ? ST_OVERFLOW : ST_OK;
            if (!cfg.continuous_mode) begin
              armed_next = 1'b0;
              phase_next = PH_IDLE;
            end else begin
              overflow_seen_next = 1'b0;
              phase_next         = PH_WAIT_START;
            end
            res.period_value = cfg.report_period_enable ? DATA_W'(period_hold_next) : '0;
            res.pulse_value  = cfg.report_pulse_enable ? DATA_W'(pulse_hold_next) : '0;
          end
        end
      end
      default: ;
    endcase
    res.capture_armed = armed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b0;
      active_channel <= 3'd0;
      phase          <= PH_IDLE;
      skip_left      <= 2'd0;
      overflow_seen  <= 1'b0;
      period_hold    <= '0;
      pulse_hold     <= '0;
    end else if (en) begin
      armed          <= armed_next;
      active_channel <= active_channel_next;
      phase          <= phase_next;
      skip_left      <= skip_left_next;
      overflow_seen  <= overflow_seen_next;
      period_hold    <= period_hold_next;
      pulse_hold     <= pulse_hold_next;
    end
  end

endmodule

>>> hdl/pwm_capture_event_sequencer.sv
// PWM input-capture event sequencer.
// Input stream s_*: one word per request. tuser carries the request kind
// (start, stop, timer event); tdata carries channel, overflow flag, capture
// flags and the four captured counter values.
// Output stream m_*: exactly one word per input word, in order. tuser flags a
// capture report; tdata carries channel, period, pulse, status, armed state
// and the software update request for the timer.
// Config port cfg_*: always ready; index 0..3 selects four-channel mode,
// continuous mode, period report enable, pulse report enable. Write only
// while no word is in flight.
// Path: input register, then the state update in the core and the result
// register behind m_*. The block takes one word per cycle while m_tready
// keeps the output draining.
// Reset (rst, synchronous): capture disarmed, holds cleared, pipeline empty,
// config back to two-channel, continuous, both reports enabled.
// A stalled m_tready holds the result; the input register still takes one
// more word, then s_tready drops until the output drains.
module pwm_capture_event_sequencer #(
  parameter int COUNTER_WIDTH = pces_pkg::COUNTER_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,  // channel_sel[2:0], overflow_flag, capture_flags[3:0],
                                 // capture_value_one..four (32b each)
  input  logic [1:0]   s_tuser,  // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata,  // report_channel[2:0], period_value[31:0],
                                 // pulse_value[31:0], status_code[1:0],
                                 // capture_armed, update_request, zero pad
  output logic         m_tuser,  // report_valid
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic         cfg_data
);
  import pces_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    advance;
  result_t res;
  result_t out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{four_channel_mode: 1'b0, continuous_mode: 1'b1,
               report_period_enable: 1'b1, report_pulse_enable: 1'b1};
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FOUR_CHANNEL: cfg.four_channel_mode    <= cfg_data;
        CFG_CONTINUOUS:   cfg.continuous_mode      <= cfg_data;
        CFG_PERIOD_EN:    cfg.report_period_enable <= cfg_data;
        CFG_PULSE_EN:     cfg.report_pulse_enable  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.req_type      <= s_tuser;
      in_item.channel_sel   <= s_tdata[2:0];
      in_item.overflow_flag <= s_tdata[3];
      in_item.capture_flags <= s_tdata[7:4];
      in_item.capture_value <= s_tdata[135:8];
    end
  end

  pces_core #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .cfg (cfg),
    .item(in_item),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= res;
  end

  assign m_tuser = out_res.report_valid;
  assign m_tdata = {1'b0, out_res.update_request, out_res.capture_armed,
                    out_res.status_code, out_res.pulse_value,
                    out_res.period_value, out_res.report_channel};

`ifndef SYNTHESIS
  a_report_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[68:67] == ST_OK || m_tdata[68:67] == ST_OVERFLOW))
    else $error("report with busy or bad-channel status");

  a_update_armed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[70] |-> m_tdata[69])
    else $error("update request while disarmed");

  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("processed word lost before output register");

  a_no_report_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[66:3] == '0))
    else $error("period or pulse nonzero without report");
`endif

endmodule

>>> dv/pwm_capture_event_sequencer_test.sv
module pwm_capture_event_sequencer_test;
  import pces_pkg::*;

  localparam int CNT_W = 32;
  localparam logic [31:0] CNT_MASK = 32'hFFFF_FFFF >> (32 - CNT_W);
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD = 60;
  localparam int PHASES = 10;
  localparam int WORDS_PER_PHASE = 123;

  typedef struct packed {
    logic [1:0]       req;
    logic [2:0]       ch;
    logic             ovf;
    logic [3:0]       flags;
    logic [3:0][31:0] val;
  } cap_word_t;

  typedef struct packed {
    logic       is_cfg;
    logic [3:0] setting;  // {four_channel, continuous, period_en, pulse_en}
    cap_word_t  word;
    logic       typed;
    result_t    res;
  } dir_row_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;
  logic         m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic         cfg_data = 1'b0;

  // typed expectation riding along with the word on the bus
  logic    word_typed = 1'b0;
  result_t word_typed_res = '0;

  logic cfg_four, cfg_cont, cfg_per_en, cfg_pul_en;
  logic        seq_armed;
  logic [2:0]  seq_chan;
  phase_t      seq_phase;
  logic [1:0]  seq_skip;
  logic        seq_ovf_seen;
  logic [31:0] seq_period, seq_pulse;

  result_t  report_q[$];
  dir_row_t dir_q[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  bit       no_gaps = 1'b0;
  bit       hold_long = 1'b0;

  pwm_capture_event_sequencer #(.COUNTER_WIDTH(CNT_W)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t predict_capture(input cap_word_t w);
    result_t    r;
    logic [1:0] a, p;
    logic       ch_ok, report;
    r = '0;
    r.report_channel = seq_chan;
    ch_ok = cfg_four ? (w.ch >= 3'd1 && w.ch <= 3'd4) : (w.ch == 3'd1 || w.ch == 3'd2);
    if (w.req == REQ_START || w.req == REQ_STOP) begin
      r.report_channel = w.ch;
      if (!ch_ok) begin
        r.status_code = ST_BAD_CHANNEL;
      end else if (w.req == REQ_STOP) begin
        seq_armed = 1'b0;
        seq_phase = PH_IDLE;
      end else if (seq_armed) begin
        r.status_code = ST_BUSY;
      end else begin
        seq_armed = 1'b1;
        seq_chan = w.ch;
        seq_phase = PH_WAIT_START;
        seq_skip = cfg_four ? 2'd0 : SKIP_COUNT;
        seq_ovf_seen = 1'b0;
        r.update_request = 1'b1;
      end
    end else if (w.req == REQ_EVENT && seq_armed) begin
      a = 2'(seq_chan - 3'd1);
      p = a ^ 2'd1;
      report = 1'b1;
      if (seq_skip != 2'd0) begin
        if (w.flags != 4'h0) seq_skip = seq_skip - 2'd1;
        report = 1'b0;
      end else begin
        if (w.ovf) begin
          if (cfg_four && seq_phase == PH_WAIT_UPDATE) seq_phase = PH_WAIT_END;
          else seq_ovf_seen = 1'b1;
        end
        if (!cfg_four) begin
          if (w.flags[a] || w.flags[p]) begin
            seq_period = w.val[a] & CNT_MASK;
            seq_pulse = w.val[p] & CNT_MASK;
          end
        end else begin
          if (seq_phase == PH_WAIT_START && w.flags[a]) begin
            seq_phase = PH_WAIT_UPDATE;
            r.update_request = 1'b1;
          end else if ((seq_phase == PH_WAIT_UPDATE || seq_phase == PH_WAIT_END) &&
                       w.flags[a]) begin
            seq_phase = PH_IDLE;
            seq_pulse = w.val[p] & CNT_MASK;
            seq_period = w.val[a] & CNT_MASK;
          end
          if (seq_phase != PH_IDLE) report = 1'b0;
        end
      end
      if (report) begin
        r.report_valid = 1'b1;
        r.status_code = seq_ovf_seen ? ST_OVERFLOW : ST_OK;
        if (!cfg_cont) begin
          seq_armed = 1'b0;
          seq_phase = PH_IDLE;
        end else begin
          seq_ovf_seen = 1'b0;
          seq_phase = PH_WAIT_START;
        end
        r.period_value = cfg_per_en ? seq_period : 32'd0;
        r.pulse_value = cfg_pul_en ? seq_pulse : 32'd0;
      end
    end
    r.capture_armed = seq_armed;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : track
    cap_word_t w;
    result_t   r;
    if (rst) begin
      cfg_four = 1'b0;
      cfg_cont = 1'b1;
      cfg_per_en = 1'b1;
      cfg_pul_en = 1'b1;
      seq_armed = 1'b0;
      seq_chan = 3'd0;
      seq_phase = PH_IDLE;
      seq_skip = 2'd0;
      seq_ovf_seen = 1'b0;
      seq_period = '0;
      seq_pulse = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FOUR_CHANNEL: cfg_four = cfg_data;
          CFG_CONTINUOUS:   cfg_cont = cfg_data;
          CFG_PERIOD_EN:    cfg_per_en = cfg_data;
          CFG_PULSE_EN:     cfg_pul_en = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        w.req = s_tuser;
        w.ch = s_tdata[2:0];
        w.ovf = s_tdata[3];
        w.flags = s_tdata[7:4];
        w.val = s_tdata[135:8];
        r = predict_capture(w);
        report_q.push_back(word_typed ? word_typed_res : r);
      end
      if (m_tvalid && m_tready) begin
        if (report_q.size() == 0) begin
          $display("%0t: unexpected word, expected none got tuser %b tdata %h",
                   $time, m_tuser, m_tdata);
          mismatches++;
        end else begin
          r = report_q.pop_front();
          check_field("report_valid", 32'(r.report_valid), 32'(m_tuser));
          check_field("report_channel", 32'(r.report_channel), 32'(m_tdata[2:0]));
          check_field("period_value", r.period_value, m_tdata[34:3]);
          check_field("pulse_value", r.pulse_value, m_tdata[66:35]);
          check_field("status_code", 32'(r.status_code), 32'(m_tdata[68:67]));
          check_field("capture_armed", 32'(r.capture_armed), 32'(m_tdata[69]));
          check_field("update_request", 32'(r.update_request), 32'(m_tdata[70]));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : sink
    int stall;
    @(posedge clk);
    forever begin
      if (hold_long) begin
        stall = LONG_HOLD;
        hold_long = 1'b0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 3);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  task automatic send_word(input cap_word_t w, input logic typed, input result_t res);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {w.val, w.flags, w.ovf, w.ch};
    s_tuser <= w.req;
    word_typed <= typed;
    word_typed_res <= res;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic finish_pending();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (report_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_setting(input logic [3:0] s);
    put_reg(CFG_FOUR_CHANNEL, s[3]);
    put_reg(CFG_CONTINUOUS, s[2]);
    put_reg(CFG_PERIOD_EN, s[1]);
    put_reg(CFG_PULSE_EN, s[0]);
    cfg_valid <= 1'b0;
  endtask

  function automatic cap_word_t cmd_word(input logic [1:0] req, input logic [2:0] ch,
                                         input logic ovf, input logic [3:0] flags,
                                         input logic [31:0] v1, input logic [31:0] v2,
                                         input logic [31:0] v3, input logic [31:0] v4);
    cap_word_t w;
    w.req = req;
    w.ch = ch;
    w.ovf = ovf;
    w.flags = flags;
    w.val = {v4, v3, v2, v1};
    return w;
  endfunction

  function automatic result_t quiet(input logic [2:0] rch, input logic [1:0] st,
                                    input logic armed, input logic upd);
    result_t r;
    r = '0;
    r.report_channel = rch;
    r.status_code = st;
    r.capture_armed = armed;
    r.update_request = upd;
    return r;
  endfunction

  initial begin : stim
    cap_word_t  w;
    logic [3:0] setting;
    logic [2:0] drv_chan;
    logic [1:0] a;
    int         pick, fsel;
    localparam logic [31:0] ONES = 32'hFFFF_FFFF;

    // two-channel, continuous, both reports on
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_EVENT, 3'd0, 1'b1, 4'hF,
                    ONES, ONES, ONES, ONES), 1'b1, quiet(3'd0, ST_OK, 1'b0, 1'b0)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_STOP, 3'd0, 1'b0, 4'h0,
                    0, 0, 0, 0), 1'b1, quiet(3'd0, ST_BAD_CHANNEL, 1'b0, 1'b0)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_START, 3'd3, 1'b0, 4'h0,
                    0, 0, 0, 0), 1'b1, quiet(3'd3, ST_BAD_CHANNEL, 1'b0, 1'b0)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_START, 3'd7, 1'b1, 4'hF,
                    ONES, ONES, ONES, ONES), 1'b1, quiet(3'd7, ST_BAD_CHANNEL, 1'b0, 1'b0)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_SPARE, 3'd5, 1'b1, 4'hF,
                    ONES, ONES, ONES, ONES), 1'b1, quiet(3'd0, ST_OK, 1'b0, 1'b0)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_START, 3'd1, 1'b0, 4'h0,
                    0, 0, 0, 0), 1'b1, quiet(3'd1, ST_OK, 1'b1, 1'b1)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_START, 3'd2, 1'b0, 4'h0,
                    0, 0, 0, 0), 1'b1, quiet(3'd2, ST_BUSY, 1'b1, 1'b0)});
    // skipped events: no flag, then two flagged ones
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_EVENT, 3'd0, 1'b1, 4'h0,
                    0, 0, 0, 0), 1'b0, result_t'('0)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_EVENT, 3'd1, 1'b1, 4'h1,
                    ONES, ONES, ONES, ONES), 1'b0, result_t'('0)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_EVENT, 3'd2, 1'b0, 4'h8,
                    32'h1234_5678, 32'h9ABC_DEF0, 0, 0), 1'b0, result_t'('0)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_EVENT, 3'd0, 1'b1, 4'h3,
                    ONES, 0, ONES, 0), 1'b0, result_t'('0)});
    // reports with held values
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_EVENT, 3'd0, 1'b0, 4'h0,
                    32'h5555_5555, 32'hAAAA_AAAA, 0, 0), 1'b0, result_t'('0)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_EVENT, 3'd4, 1'b0, 4'hC,
                    32'h0F0F_0F0F, 32'hF0F0_F0F0, ONES, ONES), 1'b0, result_t'('0)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_EVENT, 3'd6, 1'b0, 4'h2,
                    0, ONES, 0, 0), 1'b0, result_t'('0)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_STOP, 3'd2, 1'b0, 4'h0,
                    0, 0, 0, 0), 1'b1, quiet(3'd2, ST_OK, 1'b0, 1'b0)});
    // four-channel, continuous, pulse report off
    dir_q.push_back(dir_row_t'{1'b1, 4'b1110, '0, 1'b0, result_t'('0)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_START, 3'd4, 1'b0, 4'h0,
                    0, 0, 0, 0), 1'b1, quiet(3'd4, ST_OK, 1'b1, 1'b1)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_EVENT, 3'd0, 1'b0, 4'h8,
                    1, 2, 3, 4), 1'b0, result_t'('0)});
    // first overflow is the update, the second one counts
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_EVENT, 3'd0, 1'b1, 4'h0,
                    0, 0, 0, 0), 1'b0, result_t'('0)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_EVENT, 3'd0, 1'b1, 4'h0,
                    0, 0, 0, 0), 1'b0, result_t'('0)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_EVENT, 3'd0, 1'b0, 4'h8,
                    0, 0, 32'h0000_1234, ONES), 1'b0, result_t'('0)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_EVENT, 3'd0, 1'b0, 4'hF,
                    0, 0, 0, 0), 1'b0, result_t'('0)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_EVENT, 3'd0, 1'b0, 4'h8,
                    ONES, ONES, 32'hCAFE_0001, 32'h0000_0100), 1'b0, result_t'('0)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_STOP, 3'd5, 1'b0, 4'h0,
                    0, 0, 0, 0), 1'b1, quiet(3'd5, ST_BAD_CHANNEL, 1'b1, 1'b0)});
    dir_q.push_back(dir_row_t'{1'b0, 4'h0, cmd_word(REQ_START, 3'd3, 1'b0, 4'h0,
                    0, 0, 0, 0), 1'b1, quiet(3'd3, ST_BUSY, 1'b1, 1'b0)});

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_q[i]) begin
      if (dir_q[i].is_cfg) begin
        finish_pending();
        load_setting(dir_q[i].setting);
      end else begin
        send_word(dir_q[i].word, dir_q[i].typed, dir_q[i].res);
      end
    end

    drv_chan = 3'd4;
    for (int ph = 0; ph < PHASES; ph++) begin
      finish_pending();
      setting = (ph == 0) ? 4'b0000 : (ph == 1) ? 4'b1111 : 4'($urandom);
      load_setting(setting);
      no_gaps = (ph == 2 || ph == 3);
      if (ph == 3) hold_long = 1'b1;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        w.val = {$urandom(), $urandom(), $urandom(), $urandom()};
        w.ch = 3'($urandom_range(0, 7));
        w.ovf = ($urandom_range(0, 7) == 0);
        w.flags = 4'($urandom);
        a = 2'(drv_chan - 3'd1);
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          w.req = REQ_START;
          w.ch = setting[3] ? 3'($urandom_range(1, 4)) : 3'($urandom_range(1, 2));
          drv_chan = w.ch;
        end else if (pick < 9) begin
          w.req = REQ_STOP;
          w.ch = setting[3] ? 3'($urandom_range(1, 4)) : 3'($urandom_range(1, 2));
        end else if (pick < 15) begin
          w.req = 2'($urandom_range(0, 3));
          w.ovf = 1'($urandom_range(0, 1));
        end else begin
          w.req = REQ_EVENT;
          fsel = $urandom_range(0, 19);
          if (fsel < 8) w.flags = 4'b1 << a;
          else if (fsel < 11) w.flags = 4'b1 << (a ^ 2'd1);
          else if (fsel < 13) w.flags = (4'b1 << a) | (4'b1 << (a ^ 2'd1));
          else if (fsel < 15) w.flags = 4'h0;
        end
        send_word(w, 1'b0, result_t'('0));
      end
    end
    finish_pending();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
